// ----- design/u8u16_pkg.sv -----
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
  localparam logic [2:0]  RUN_MAX     = 3'd6;

  // Results owed for one accepted byte: rep_cnt replacement units first,
  // then the final unit (a decoded unit or the terminator) if fin_vld.
  typedef struct packed {
    logic [2:0]  rep_cnt;
    logic        fin_vld;
    logic [15:0] fin_unit;
    logic        fin_eos;
  } run_t;

endpackage

// ----- design/u8u16_decode.sv -----
`timescale 1ns / 1ps

module u8u16_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic [15:0]         out_limit_i,
  output u8u16_pkg::run_t     run_o
);
  import u8u16_pkg::*;

  typedef enum logic [1:0] {
    CLS_SINGLE,
    CLS_CONT,
    CLS_LEAD
  } byte_class_e;

  logic [2:0]  exp_len_q, exp_len_d;
  logic [2:0]  taken_q, taken_d;
  logic [15:0] acc_q, acc_d;
  logic        ovf_q, ovf_d;
  logic [15:0] emitted_q, emitted_d;

  byte_class_e cls;
  logic        pending;
  logic [15:0] acc_sh;
  logic        ovf_sh;
  logic [2:0]  taken_inc;
  logic        bad_val;
  logic [2:0]  rep;
  logic        is_unit;
  logic        is_term;
  logic [15:0] unit;
  logic [15:0] room;
  logic [2:0]  kept_rep;
  logic        unit_kept;

  always_comb begin
    if (data_byte_i[7] == 1'b0) begin
      cls = CLS_SINGLE;
    end else if (data_byte_i[7:6] == 2'b10 || data_byte_i[7:1] == 7'h7F) begin
      cls = CLS_CONT;
    end else begin
      cls = CLS_LEAD;
    end
  end

  assign pending   = (exp_len_q != 3'd0);
  // keep 16 value bits and a sticky flag for anything shifted past them
  assign acc_sh    = {acc_q[9:0], data_byte_i[5:0]};
  assign ovf_sh    = ovf_q | (|acc_q[15:10]);
  assign taken_inc = taken_q + 3'd1;
  assign bad_val   = ovf_sh || (acc_sh[15:11] == 5'b11011);

  always_comb begin
    exp_len_d = exp_len_q;
    taken_d   = taken_q;
    acc_d     = acc_q;
    ovf_d     = ovf_q;
    rep       = 3'd0;
    is_unit   = 1'b0;
    is_term   = 1'b0;
    unit      = 16'd0;

    if (pending && cls == CLS_CONT) begin
      acc_d   = acc_sh;
      ovf_d   = ovf_sh;
      taken_d = taken_inc;
      if (taken_inc >= exp_len_q) begin
        is_unit   = 1'b1;
        unit      = bad_val ? REPL_UNIT : acc_sh;
        exp_len_d = 3'd0;
        taken_d   = 3'd0;
        acc_d     = 16'd0;
        ovf_d     = 1'b0;
      end
    end else begin
      if (pending) begin
        rep       = taken_q;
        exp_len_d = 3'd0;
        taken_d   = 3'd0;
        acc_d     = 16'd0;
        ovf_d     = 1'b0;
      end
      unique case (cls)
        CLS_SINGLE: begin
          if (data_byte_i == 8'd0) begin
            is_term = 1'b1;
          end else begin
            is_unit = 1'b1;
            unit    = {8'd0, data_byte_i};
          end
        end
        CLS_CONT: begin
          is_unit = 1'b1;
          unit    = REPL_UNIT;
        end
        CLS_LEAD: begin
          taken_d = 3'd1;
          ovf_d   = 1'b0;
          if (data_byte_i <= 8'hDF) begin
            exp_len_d = 3'd2;
            acc_d     = {11'd0, data_byte_i[4:0]};
          end else if (data_byte_i <= 8'hEF) begin
            exp_len_d = 3'd3;
            acc_d     = {12'd0, data_byte_i[3:0]};
          end else if (data_byte_i <= 8'hF7) begin
            exp_len_d = 3'd4;
            acc_d     = {13'd0, data_byte_i[2:0]};
          end else if (data_byte_i <= 8'hFB) begin
            exp_len_d = 3'd5;
            acc_d     = {14'd0, data_byte_i[1:0]};
          end else begin
            exp_len_d = RUN_MAX;
            acc_d     = {15'd0, data_byte_i[0]};
          end
        end
        default: begin
          exp_len_d = 3'd0;
        end
      endcase
    end
  end

  // output limit: units are kept in order while the string has room
  always_comb begin
    room      = (emitted_q < out_limit_i) ? (out_limit_i - emitted_q) : 16'd0;
    kept_rep  = (room < {13'd0, rep}) ? room[2:0] : rep;
    unit_kept = is_unit && (room > {13'd0, rep});
    if (is_term) begin
      emitted_d = 16'd0;
    end else begin
      emitted_d = emitted_q + {13'd0, kept_rep} + {15'd0, unit_kept};
    end
  end

  assign run_o.rep_cnt  = kept_rep;
  assign run_o.fin_vld  = is_term | unit_kept;
  assign run_o.fin_unit = unit;
  assign run_o.fin_eos  = is_term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= 3'd0;
      taken_q   <= 3'd0;
      acc_q     <= 16'd0;
      ovf_q     <= 1'b0;
      emitted_q <= 16'd0;
    end else if (accept_i) begin
      exp_len_q <= exp_len_d;
      taken_q   <= taken_d;
      acc_q     <= acc_d;
      ovf_q     <= ovf_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

// ----- design/utf8_to_utf16_bmp_decoder_top.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid / stall   | in_data_byte_i
// out     | output    | out_valid / stall  | out_code_unit_o, out_end_of_string_o,
//         |           |                    | out_last_in_run_o
// cfg     | input     | cfg_valid / ready  | cfg_out_limit_i
//
// A byte is decoded in the cycle it is accepted; its results (0 to 6) leave
// through the run register and the output register, one per cycle unless
// stalled. Unstalled, bytes giving at most one result go at one per cycle; a
// byte giving more than one result holds the input while the run drains.
// Reset (async, active low) clears the sequence state, unit count and output
// valid, and sets out_limit to 0xFFFF. Output stall holds the output register
// and, once the pending run is down to its last result, the input too.
module utf8_to_utf16_bmp_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_code_unit_o,
  output logic        out_end_of_string_o,
  output logic        out_last_in_run_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_out_limit_i
);
  import u8u16_pkg::*;

  logic [15:0] out_limit_q;
  run_t        run_q, run_d, new_run;
  logic [2:0]  run_left;
  logic        pop;
  logic        in_accept;
  logic        out_valid_q;
  logic [15:0] out_unit_q, out_unit_d;
  logic        out_eos_q, out_eos_d;
  logic        out_last_q, out_last_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      out_limit_q <= cfg_out_limit_i;
    end
  end

  u8u16_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (in_data_byte_i),
    .out_limit_i (out_limit_q),
    .run_o       (new_run)
  );

  assign run_left   = run_q.rep_cnt + {2'd0, run_q.fin_vld};
  assign pop        = (run_left != 3'd0) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (run_left > 3'd1) || ((run_left == 3'd1) && !pop);
  assign in_accept  = in_valid_i && !in_stall_o;

  // replacements go first, then the final unit
  always_comb begin
    run_d      = run_q;
    out_unit_d = run_q.fin_unit;
    out_eos_d  = run_q.fin_eos;
    out_last_d = 1'b1;
    if (run_q.rep_cnt != 3'd0) begin
      out_unit_d    = REPL_UNIT;
      out_eos_d     = 1'b0;
      out_last_d    = (run_q.rep_cnt == 3'd1) && !run_q.fin_vld;
      run_d.rep_cnt = run_q.rep_cnt - 3'd1;
    end else begin
      run_d.fin_vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        run_q <= new_run;
      end else if (pop) begin
        run_q <= run_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_unit_q <= out_unit_d;
      out_eos_q  <= out_eos_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_code_unit_o     = out_unit_q;
  assign out_end_of_string_o = out_eos_q;
  assign out_last_in_run_o   = out_last_q;

endmodule

// ----- design/u8u16_checker.sv -----
`timescale 1ns / 1ps

module u8u16_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] out_code_unit_o,
  input logic        out_end_of_string_o,
  input logic        out_last_in_run_o
);
  import u8u16_pkg::*;

  // terminator carries a zero unit
  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_end_of_string_o |-> out_code_unit_o == 16'd0)
    else $error("terminator with nonzero code unit");

  // terminator is always the last result of its byte
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_end_of_string_o |-> out_last_in_run_o)
    else $error("terminator not last in run");

  // only replacement units can precede another result of the same byte
  a_mid_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_in_run_o |-> out_code_unit_o == REPL_UNIT)
    else $error("non-replacement unit in the middle of a run");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_code_unit_o))
    else $error("stalled output item changed");

endmodule

bind utf8_to_utf16_bmp_decoder_top u8u16_checker u_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .out_code_unit_o     (out_code_unit_o),
  .out_end_of_string_o (out_end_of_string_o),
  .out_last_in_run_o   (out_last_in_run_o)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import u8u16_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 70;
  localparam int NUM_PHASES  = 6;
  localparam int DIR_ROWS    = 28;
  localparam int CALM_PHASE  = 3;
  localparam int SETTLE_CYC  = 8;

  typedef struct packed {
    logic [15:0] unit;
    logic        eos;
    logic        last;
  } unit_rec_t;

  // typed = 1: the expectation is the row itself (one unit if has_unit, else none)
  typedef struct packed {
    logic [7:0]  din;
    logic        typed;
    logic        has_unit;
    logic [15:0] unit;
    logic        eos;
  } dir_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_data_byte_i  = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [15:0] out_code_unit_o;
  logic        out_end_of_string_o;
  logic        out_last_in_run_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_out_limit_i = 16'h0000;

  logic        calm = 1'b0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // decoder state as the testbench sees it
  int          pend_len;
  int          pend_taken;
  logic [31:0] pend_acc;
  logic [15:0] units_kept;
  logic [15:0] out_limit_q;

  unit_rec_t   run_units[$];
  unit_rec_t   expected_units[$];
  logic [7:0]  chunk_bytes[$];

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{8'h41, 1'b1, 1'b1, 16'h0041, 1'b0},
    '{8'h7F, 1'b1, 1'b1, 16'h007F, 1'b0},
    '{8'h01, 1'b1, 1'b1, 16'h0001, 1'b0},
    '{8'h80, 1'b1, 1'b1, REPL_UNIT, 1'b0},
    '{8'hBF, 1'b1, 1'b1, REPL_UNIT, 1'b0},
    '{8'hFE, 1'b1, 1'b1, REPL_UNIT, 1'b0},
    '{8'hFF, 1'b1, 1'b1, REPL_UNIT, 1'b0},
    '{8'hC3, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hA9, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hED, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hA0, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},   // surrogate D800
    '{8'hEF, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0},   // FFFF, top of the plane
    '{8'hF4, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h90, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},   // above the plane
    '{8'hFD, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},   // five replacements, then terminator
    '{8'hF8, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h41, 1'b0, 1'b0, 16'h0000, 1'b0}    // replacement for the lead, then 'A'
  };

  utf8_to_utf16_bmp_decoder_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_data_byte_i     (in_data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_code_unit_o    (out_code_unit_o),
    .out_end_of_string_o(out_end_of_string_o),
    .out_last_in_run_o  (out_last_in_run_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_out_limit_i    (cfg_out_limit_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic is_cont(input logic [7:0] b);
    return (b >= 8'h80 && b <= 8'hBF) || b >= 8'hFE;
  endfunction

  function automatic logic [15:0] finished_unit(input logic [31:0] v);
    if ((v >= 32'hD800 && v <= 32'hDFFF) || v > 32'hFFFF) return REPL_UNIT;
    return v[15:0];
  endfunction

  function automatic void keep_unit(input logic [15:0] u);
    if (units_kept < out_limit_q) begin
      units_kept = units_kept + 16'd1;
      run_units.push_back('{u, 1'b0, 1'b0});
    end
  endfunction

  function automatic void clear_seq();
    pend_len   = 0;
    pend_taken = 0;
    pend_acc   = '0;
  endfunction

  function automatic void reset_decoder_state();
    clear_seq();
    units_kept  = '0;
    out_limit_q = LIMIT_RESET;
  endfunction

  // Fills run_units with the units one accepted byte produces.
  function automatic void decode_byte(input logic [7:0] b);
    int        n;
    unit_rec_t tail;
    run_units.delete();
    if (pend_len != 0 && is_cont(b)) begin
      pend_acc   = (pend_acc << 6) | 32'(b & 8'h3F);
      pend_taken = pend_taken + 1;
      if (pend_taken >= pend_len) begin
        keep_unit(finished_unit(pend_acc));
        clear_seq();
      end
    end else begin
      if (pend_len != 0) begin
        for (int i = 0; i < pend_taken && i < 6; i++) keep_unit(REPL_UNIT);
        clear_seq();
      end
      if (b == 8'h00) begin
        run_units.push_back('{16'h0000, 1'b1, 1'b0});
        clear_seq();
        units_kept = '0;
      end else if (b < 8'h80) begin
        keep_unit({8'h00, b});
      end else if (is_cont(b)) begin
        keep_unit(REPL_UNIT);
      end else begin
        n = (b <= 8'hDF) ? 2 : (b <= 8'hEF) ? 3 : (b <= 8'hF7) ? 4 : (b <= 8'hFB) ? 5 : 6;
        pend_len   = n;
        pend_taken = 1;
        pend_acc   = 32'(b) & ((32'd1 << (7 - n)) - 32'd1);
      end
    end
    if (run_units.size() > 0) begin
      tail = run_units[run_units.size() - 1];
      tail.last = 1'b1;
      run_units[run_units.size() - 1] = tail;
    end
  endfunction

  function automatic logic [7:0] rand_cont();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'hFE;
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // One random piece of the byte stream: mostly well-formed sequences, some noise.
  task automatic gen_chunk();
    int          kind;
    int          n;
    int          conts;
    logic [7:0]  lead_pfx [2:6];
    lead_pfx[2] = 8'hC0; lead_pfx[3] = 8'hE0; lead_pfx[4] = 8'hF0;
    lead_pfx[5] = 8'hF8; lead_pfx[6] = 8'hFC;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      chunk_bytes.push_back(8'($urandom_range(1, 127)));
    end else if (kind < 76 || (kind >= 84 && kind < 90)) begin
      if      (kind < 45) n = 2;
      else if (kind < 60) n = 3;
      else if (kind < 67) n = 4;
      else if (kind < 72) n = 5;
      else if (kind < 76) n = 6;
      else                n = $urandom_range(2, 6);
      conts = (kind < 76) ? n - 1 : $urandom_range(0, n - 2);
      if (n == 3 && kind < 76 && $urandom_range(0, 3) == 0) begin
        // land in the surrogate range
        chunk_bytes.push_back(8'hED);
        chunk_bytes.push_back(8'hA0 | 8'($urandom_range(0, 31)));
        conts = conts - 1;
      end else begin
        chunk_bytes.push_back(lead_pfx[n] | 8'($urandom_range(0, (1 << (7 - n)) - 1)));
      end
      repeat (conts) chunk_bytes.push_back(rand_cont());
    end else if (kind < 84) begin
      chunk_bytes.push_back(8'h00);
    end else if (kind < 96) begin
      chunk_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      chunk_bytes.push_back(rand_cont() | 8'($urandom_range(0, 1) << 6));
    end
  endtask

  // Called right after a rising edge; returns at the edge where the item is taken.
  task automatic send_byte(input logic [7:0] b);
    in_valid_i     <= 1'b1;
    in_data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 99) < 35) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_valid_i     <= 1'b1;
    cfg_out_limit_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    out_limit_q = v;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    unit_rec_t exp_u;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_units.size() == 0) begin
        $error("unexpected item: code_unit %h end_of_string %b last_in_run %b",
               out_code_unit_o, out_end_of_string_o, out_last_in_run_o);
        mismatch_count++;
      end else begin
        exp_u = expected_units.pop_front();
        if (out_code_unit_o !== exp_u.unit) begin
          $error("code_unit: expected %h, actual %h", exp_u.unit, out_code_unit_o);
          mismatch_count++;
        end
        if (out_end_of_string_o !== exp_u.eos) begin
          $error("end_of_string: expected %b, actual %b", exp_u.eos, out_end_of_string_o);
          mismatch_count++;
        end
        if (out_last_in_run_o !== exp_u.last) begin
          $error("last_in_run: expected %b, actual %b", exp_u.last, out_last_in_run_o);
          mismatch_count++;
        end
      end
    end
    out_stall_i <= !calm && ($urandom_range(0, 99) < 35);
  end

  initial begin : stimulus
    int          sent;
    logic [7:0]  b;
    logic [15:0] lim;
    reset_decoder_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].din);
      decode_byte(dir_rows[i].din);
      if (!dir_rows[i].typed) begin
        foreach (run_units[k]) expected_units.push_back(run_units[k]);
      end else if (dir_rows[i].has_unit) begin
        expected_units.push_back('{dir_rows[i].unit, dir_rows[i].eos, 1'b1});
      end
      idle_gap();
    end
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       lim = 16'd0;
        1:       lim = 16'd2;
        2:       lim = 16'd7;
        3:       lim = 16'hFFFF;
        4:       lim = 16'($urandom_range(1, 20));
        default: lim = 16'($urandom_range(0, 65535));
      endcase
      write_limit(lim);
      calm <= (phase == CALM_PHASE);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        gen_chunk();
        while (chunk_bytes.size() != 0) begin
          b = chunk_bytes.pop_front();
          send_byte(b);
          decode_byte(b);
          foreach (run_units[k]) expected_units.push_back(run_units[k]);
          sent++;
          idle_gap();
        end
      end
      drain();
    end

    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
